// ===== hdl/nmea_sentence_checksum_parser_macros.svh =====
// ---------------------------------------------------------------------------
// NMEA checksum parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKSUM_PARSER_MACROS_SVH
`define NMEA_SENTENCE_CHECKSUM_PARSER_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define NSCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define NSCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/nscp_pkg.sv =====
// ---------------------------------------------------------------------------
// NMEA checksum parser package
// Widths, character codes and the types shared between the parser modules.
// ---------------------------------------------------------------------------
`default_nettype none

package nscp_pkg;

  localparam int ByteW  = 8;
  localparam int FieldW = 4;

  // Character codes of the sentence framing
  localparam logic [ByteW-1:0] ChDollar   = 8'd36;
  localparam logic [ByteW-1:0] ChStar     = 8'd42;
  localparam logic [ByteW-1:0] ChComma    = 8'd44;
  localparam logic [ByteW-1:0] ChZero     = 8'd48;
  localparam logic [ByteW-1:0] HexAlphaOfs = 8'd55;
  localparam logic [3:0]       NibbleMask = 4'b1111;

  localparam logic [FieldW-1:0] FieldMax     = 4'd15;
  localparam logic [FieldW-1:0] FixIdxReset  = 4'd6;

  // Byte held in the input register
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] rx_byte;
  } nscp_item_t;

  // One result transaction
  typedef struct packed {
    logic              checksum_ok;
    logic [ByteW-1:0]  computed_checksum;
    logic [FieldW-1:0] field_count;
    logic [ByteW-1:0]  fix_quality;
  } nscp_result_t;

endpackage

`default_nettype wire

// ===== hdl/nscp_if.sv =====
// ---------------------------------------------------------------------------
// NMEA checksum parser channel interfaces
// Valid/ready channels for received bytes, results and the config write.
// ---------------------------------------------------------------------------
`default_nettype none

interface nscp_in_if;
  import nscp_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nscp_out_if;
  import nscp_pkg::*;
  logic              valid;
  logic              ready;
  logic              checksum_ok;
  logic [ByteW-1:0]  computed_checksum;
  logic [FieldW-1:0] field_count;
  logic [ByteW-1:0]  fix_quality;
  modport source (output valid, output checksum_ok, output computed_checksum,
                  output field_count, output fix_quality, input ready);
  modport sink   (input valid, input checksum_ok, input computed_checksum,
                  input field_count, input fix_quality, output ready);
endinterface

interface nscp_cfg_if;
  import nscp_pkg::*;
  logic              valid;
  logic              ready;
  logic [FieldW-1:0] fix_field_index;
  modport source (output valid, output fix_field_index, input ready);
  modport sink   (input valid, input fix_field_index, output ready);
endinterface

`default_nettype wire

// ===== hdl/nscp_in_stage.sv =====
// ---------------------------------------------------------------------------
// NMEA checksum parser input stage
// Registers each accepted byte and holds it until the parser consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

`include "nmea_sentence_checksum_parser_macros.svh"

module nscp_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  output logic                 in_ready,
  input  logic                 consume,
  output nscp_pkg::nscp_item_t item
);
  import nscp_pkg::*;

  logic             valid_r;
  logic [ByteW-1:0] byte_r;

  // Take a new byte whenever the register is empty or drains this cycle
  assign in_ready = !valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
  end

  assign item.valid   = valid_r;
  assign item.rx_byte = byte_r;

  `NSCP_ASSERT_NXT(a_hold_byte, valid_r && !consume,
                   valid_r && $stable(byte_r), "stalled input byte was lost")
  `NSCP_ASSERT_IMP(a_consume_valid, consume, valid_r, "consumed an empty input register")

endmodule

`default_nettype wire

// ===== hdl/nscp_core.sv =====
// ---------------------------------------------------------------------------
// NMEA checksum parser sentence core
// Tracks sentence phase, running XOR, field count and fix byte per byte.
// ---------------------------------------------------------------------------
`default_nettype none

`include "nmea_sentence_checksum_parser_macros.svh"

module nscp_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  nscp_pkg::nscp_item_t   item,
  input  logic                   out_free,
  input  logic                   cfg_we,
  input  logic [3:0]             cfg_fix_idx,
  output logic                   consume,
  output logic                   emit,
  output nscp_pkg::nscp_result_t result
);
  import nscp_pkg::*;

  typedef enum logic [1:0] {
    PhBody = 2'd0,
    PhHex1 = 2'd1,
    PhHex2 = 2'd2,
    PhIdle = 2'd3
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [ByteW-1:0]  xor_r, xor_nxt;
  logic [FieldW-1:0] fld_r, fld_nxt;
  logic [ByteW-1:0]  fix_r, fix_nxt;
  logic [ByteW-1:0]  hex1_r, hex1_nxt;
  logic [FieldW-1:0] fix_idx_r;
  logic              is_dollar;
  logic              sum_match;

  // Uppercase ASCII hex digit of a nibble
  function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] nib);
    logic [3:0] n;
    n = nib & NibbleMask;
    return (n < 4'd10) ? ({4'b0, n} + ChZero) : ({4'b0, n} + HexAlphaOfs);
  endfunction

  assign is_dollar = (item.rx_byte == ChDollar);

  // Result leaves on the second hex character
  assign emit    = item.valid && !is_dollar && (phase_r == PhHex2);
  assign consume = item.valid && (!emit || out_free);

  assign sum_match = (hex1_r == hex_digit(xor_r[7:4])) &&
                     (item.rx_byte == hex_digit(xor_r[3:0]));

  assign result.checksum_ok       = sum_match;
  assign result.computed_checksum = xor_r;
  assign result.field_count       = fld_r;
  assign result.fix_quality       = fix_r - ChZero;

  // Next sentence state for the byte being consumed
  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    fld_nxt   = fld_r;
    fix_nxt   = fix_r;
    hex1_nxt  = hex1_r;
    if (is_dollar) begin
      phase_nxt = PhBody;
      xor_nxt   = '0;
      fld_nxt   = '0;
      fix_nxt   = ChZero;
      hex1_nxt  = '0;
    end else begin
      unique case (phase_r)
        PhBody: begin
          if (item.rx_byte == ChStar) begin
            phase_nxt = PhHex1;
          end else begin
            xor_nxt = xor_r ^ item.rx_byte;
            if (item.rx_byte == ChComma) begin
              if (fld_r != FieldMax) begin
                fld_nxt = fld_r + 4'd1;
              end
            end else if (fld_r == fix_idx_r) begin
              fix_nxt = item.rx_byte;
            end
          end
        end
        PhHex1: begin
          hex1_nxt  = item.rx_byte;
          phase_nxt = PhHex2;
        end
        PhHex2: begin
          phase_nxt = PhIdle;
        end
        PhIdle: begin
          phase_nxt = PhIdle;
        end
        default: begin
          phase_nxt = PhIdle;
        end
      endcase
    end
  end

  // Hold sentence state and the fix field register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PhIdle;
      xor_r     <= '0;
      fld_r     <= '0;
      fix_r     <= ChZero;
      hex1_r    <= '0;
      fix_idx_r <= FixIdxReset;
    end else begin
      if (consume) begin
        phase_r <= phase_nxt;
        xor_r   <= xor_nxt;
        fld_r   <= fld_nxt;
        fix_r   <= fix_nxt;
        hex1_r  <= hex1_nxt;
      end
      if (cfg_we) begin
        fix_idx_r <= cfg_fix_idx;
      end
    end
  end

  `NSCP_ASSERT_NXT(a_idle_after_result, consume && emit, phase_r == PhIdle,
                   "parser did not go idle after a result")
  `NSCP_ASSERT_NXT(a_field_monotonic,
                   consume && !is_dollar && (phase_r == PhBody),
                   fld_r >= $past(fld_r), "field count decreased inside a sentence")

endmodule

`default_nettype wire

// ===== hdl/nscp_out_stage.sv =====
// ---------------------------------------------------------------------------
// NMEA checksum parser output stage
// Holds one result transaction until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

`include "nmea_sentence_checksum_parser_macros.svh"

module nscp_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  nscp_pkg::nscp_result_t result,
  output logic                   out_free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output nscp_pkg::nscp_result_t out_data
);
  import nscp_pkg::*;

  logic         valid_r;
  nscp_result_t data_r;

  // Register is free when empty or its transaction leaves this cycle
  assign out_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  `NSCP_ASSERT_IMP(a_no_overwrite, load, out_free, "result overwrote a pending transaction")

endmodule

`default_nettype wire

// ===== hdl/nmea_sentence_checksum_parser.sv =====
// ---------------------------------------------------------------------------
// NMEA sentence checksum parser
// Verifies the checksum of NMEA 0183 sentences from a received byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   in_bus   one received byte per transaction (rx_byte).
//   out_bus  one result per sentence: checksum_ok, computed_checksum,
//            field_count and fix_quality, given on the second hex character
//            after the star. Bytes before the first dollar sign and after a
//            result are dropped until the next dollar sign.
//   cfg_bus  write of fix_field_index; always ready, write only while idle.
// Throughput: one byte per cycle unless a result is due while out_bus holds
//   one; the per-byte update is a single pass of compare and XOR logic
//   between the input register and the result register.
// Path: consuming the last hex character loads the result and sets out_bus valid.
// Reset: synchronous, active low; the parser waits for a dollar sign and
//   fix_field_index returns to 6.
// Stall: a pending result holds out_bus; bytes that give no result keep
//   flowing, and in_bus stalls only when another result is due.
// ---------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_checksum_parser (
  input  logic       clk,
  input  logic       rst_n,
  nscp_in_if.sink    in_bus,
  nscp_out_if.source out_bus,
  nscp_cfg_if.sink   cfg_bus
);
  import nscp_pkg::*;

  nscp_item_t   item;
  nscp_result_t result;
  nscp_result_t out_data;
  logic         consume;
  logic         emit;
  logic         out_free;

  // Register incoming bytes
  nscp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_byte  (in_bus.rx_byte),
    .in_ready (in_bus.ready),
    .consume  (consume),
    .item     (item)
  );

  // Update sentence state and form results
  assign cfg_bus.ready = 1'b1;

  nscp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (item),
    .out_free    (out_free),
    .cfg_we      (cfg_bus.valid),
    .cfg_fix_idx (cfg_bus.fix_field_index),
    .consume     (consume),
    .emit        (emit),
    .result      (result)
  );

  // Hold results for the receiver
  nscp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (consume && emit),
    .result    (result),
    .out_free  (out_free),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_data  (out_data)
  );

  assign out_bus.checksum_ok       = out_data.checksum_ok;
  assign out_bus.computed_checksum = out_data.computed_checksum;
  assign out_bus.field_count       = out_data.field_count;
  assign out_bus.fix_quality       = out_data.fix_quality;

endmodule

`default_nettype wire
